>>> rtl/esct_pkg.sv
// Shared constants and types for the event side cache table.
package esct_pkg;

    localparam int ENTRIES  = 32;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W    = 64;
    localparam int CODE_W   = 8;
    localparam int RESID_W  = 24;
    localparam int LEN_W    = 17;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_TAKE  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
        logic [RESID_W-1:0] residual;
        logic [LEN_W-1:0]   length;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> rtl/esct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module esct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/event_side_cache_table.sv
// Event side cache table: keyed completion-event store with a slot-by-slot scan.
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------------
//  in      | i_in_valid / o_in_ready | i_command, i_key_address, i_in_code,
//          |                         | i_in_residual, i_in_length
//  out     | o_out_valid/i_out_ready | o_hit, o_out_code, o_out_residual,
//          |                         | o_out_length, o_overwrote
//
// A store walks the valid bits one slot per cycle.
// A take streams slots through the table RAM and one key comparator,
// one slot per cycle, with each registered read issued one slot ahead of the compare.
// The input side is ready only while idle; one item is worked at a time.
// Reset clears the valid bits and the control state; slot contents are left as is.
// A held result does not block acceptance; the finished item waits until it drains.
module event_side_cache_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [esct_pkg::KEY_W-1:0]   i_key_address,
    input  logic [esct_pkg::CODE_W-1:0]  i_in_code,
    input  logic [esct_pkg::RESID_W-1:0] i_in_residual,
    input  logic [esct_pkg::LEN_W-1:0]   i_in_length,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_hit,
    output logic [esct_pkg::CODE_W-1:0]  o_out_code,
    output logic [esct_pkg::RESID_W-1:0] o_out_residual,
    output logic [esct_pkg::LEN_W-1:0]   o_out_length,
    output logic                         o_overwrote
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STORE,
        ST_TAKE,
        ST_DONE
    } t_state;

    t_state r_state, n_state;

    logic [esct_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                         r_issue, n_issue;
    logic                         r_cmp_vld, n_cmp_vld;
    logic [esct_pkg::IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic [esct_pkg::ENTRIES-1:0] r_valid, n_valid;

    logic                         r_cmd, n_cmd;
    logic [esct_pkg::KEY_W-1:0]   r_key, n_key;
    logic [esct_pkg::CODE_W-1:0]  r_code, n_code;
    logic [esct_pkg::RESID_W-1:0] r_resid, n_resid;
    logic [esct_pkg::LEN_W-1:0]   r_len, n_len;
    logic                         r_hit, n_hit;
    logic                         r_ovw, n_ovw;

    logic                         r_out_valid, n_out_valid;
    logic                         r_out_hit, n_out_hit;
    logic [esct_pkg::CODE_W-1:0]  r_out_code, n_out_code;
    logic [esct_pkg::RESID_W-1:0] r_out_resid, n_out_resid;
    logic [esct_pkg::LEN_W-1:0]   r_out_len, n_out_len;
    logic                         r_out_ovw, n_out_ovw;

    logic                         ram_we;
    logic [esct_pkg::IDX_W-1:0]   ram_wa;
    esct_pkg::t_entry             ram_wd;
    esct_pkg::t_entry             ram_rd;
    logic [esct_pkg::ENTRY_W-1:0] ram_rd_bits;

    esct_ram #(
        .WIDTH (esct_pkg::ENTRY_W),
        .DEPTH (esct_pkg::ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_bits)
    );

    assign ram_rd = esct_pkg::t_entry'(ram_rd_bits);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_valid     = r_valid;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_code      = r_code;
        n_resid     = r_resid;
        n_len       = r_len;
        n_hit       = r_hit;
        n_ovw       = r_ovw;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_code  = r_out_code;
        n_out_resid = r_out_resid;
        n_out_len   = r_out_len;
        n_out_ovw   = r_out_ovw;

        ram_we = 1'b0;
        ram_wa = r_idx;
        ram_wd = '{key: r_key, code: r_code, residual: r_resid, length: r_len};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = i_command;
                    n_key     = i_key_address;
                    n_code    = i_in_code;
                    n_resid   = i_in_residual;
                    n_len     = i_in_length;
                    n_hit     = 1'b0;
                    n_ovw     = 1'b0;
                    n_idx     = '0;
                    n_issue   = 1'b1;
                    n_cmp_vld = 1'b0;
                    n_state   = (i_command == esct_pkg::CMD_TAKE) ? ST_TAKE : ST_STORE;
                end
            end
            ST_STORE: begin
                if (!r_valid[r_idx]) begin
                    ram_we           = 1'b1;
                    n_valid[r_idx]   = 1'b1;
                    n_state          = ST_DONE;
                end else if (r_idx == esct_pkg::LAST_IDX) begin
                    // table full: replace slot zero
                    ram_we  = 1'b1;
                    ram_wa  = '0;
                    n_ovw   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
                if (n_state == ST_DONE) begin
                    n_code  = '0;
                    n_resid = '0;
                    n_len   = '0;
                end
            end
            ST_TAKE: begin
                // issue reads one slot ahead of the compare
                n_cmp_vld = r_issue;
                n_cmp_idx = r_idx;
                if (r_issue) begin
                    if (r_idx == esct_pkg::LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    if (r_valid[r_cmp_idx] && (ram_rd.key == r_key)) begin
                        n_hit              = 1'b1;
                        n_code             = ram_rd.code;
                        n_resid            = ram_rd.residual;
                        n_len              = ram_rd.length;
                        n_valid[r_cmp_idx] = 1'b0;
                        n_cmp_vld          = 1'b0;
                        n_issue            = 1'b0;
                        n_state            = ST_DONE;
                    end else if (r_cmp_idx == esct_pkg::LAST_IDX) begin
                        n_code    = '0;
                        n_resid   = '0;
                        n_len     = '0;
                        n_cmp_vld = 1'b0;
                        n_issue   = 1'b0;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_out_code  = r_code;
                    n_out_resid = r_resid;
                    n_out_len   = r_len;
                    n_out_ovw   = r_ovw;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_cmp_vld   <= n_cmp_vld;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_code      <= n_code;
        r_resid     <= n_resid;
        r_len       <= n_len;
        r_hit       <= n_hit;
        r_ovw       <= n_ovw;
        r_out_hit   <= n_out_hit;
        r_out_code  <= n_out_code;
        r_out_resid <= n_out_resid;
        r_out_len   <= n_out_len;
        r_out_ovw   <= n_out_ovw;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_out_code     = r_out_code;
    assign o_out_residual = r_out_resid;
    assign o_out_length   = r_out_len;
    assign o_overwrote    = r_out_ovw && (r_cmd == esct_pkg::CMD_STORE || !r_out_hit);

endmodule

>>> bench/event_side_cache_table_test.sv
// Self-checking testbench for the event side cache table: stores, takes, full-table replacement.
`timescale 1ns / 1ps

module event_side_cache_table_test;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int TAIL_CYCLES     = 2 * esct_pkg::ENTRIES + 8;
    localparam int ITEM_TARGET     = 1400;

    typedef struct packed {
        logic                         hit;
        logic [esct_pkg::CODE_W-1:0]  code;
        logic [esct_pkg::RESID_W-1:0] residual;
        logic [esct_pkg::LEN_W-1:0]   length;
        logic                         overwrote;
    } t_completion;

    // Mirror of the slot table; predicts one completion per accepted item.
    class t_event_slot_predictor;
        logic                         slot_used  [esct_pkg::ENTRIES];
        logic [esct_pkg::KEY_W-1:0]   slot_addr  [esct_pkg::ENTRIES];
        logic [esct_pkg::CODE_W-1:0]  slot_code  [esct_pkg::ENTRIES];
        logic [esct_pkg::RESID_W-1:0] slot_resid [esct_pkg::ENTRIES];
        logic [esct_pkg::LEN_W-1:0]   slot_len   [esct_pkg::ENTRIES];
        t_completion                  due_events [$];
        int stores, takes, hits, replaced, mismatches, results;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            stores = 0;
            takes = 0;
            hits = 0;
            replaced = 0;
            mismatches = 0;
            results = 0;
        endfunction

        function int occupancy();
            int n;
            n = 0;
            foreach (slot_used[i]) if (slot_used[i]) n++;
            return n;
        endfunction

        function void note_item(logic cmd, logic [esct_pkg::KEY_W-1:0] key,
                                logic [esct_pkg::CODE_W-1:0] code,
                                logic [esct_pkg::RESID_W-1:0] resid,
                                logic [esct_pkg::LEN_W-1:0] len);
            t_completion outcome;
            int          idx;
            int          i;
            outcome = '0;
            idx = -1;
            if (cmd == esct_pkg::CMD_STORE) begin
                stores++;
                for (i = esct_pkg::ENTRIES - 1; i >= 0; i--) if (!slot_used[i]) idx = i;
                // Full table: replace slot 0.
                if (idx < 0) begin
                    idx = 0;
                    outcome.overwrote = 1'b1;
                    replaced++;
                end
                slot_used[idx]  = 1'b1;
                slot_addr[idx]  = key;
                slot_code[idx]  = code;
                slot_resid[idx] = resid;
                slot_len[idx]   = len;
            end else begin
                takes++;
                for (i = 0; i < esct_pkg::ENTRIES && !outcome.hit; i++) begin
                    if (slot_used[i] && slot_addr[i] == key) begin
                        outcome.hit      = 1'b1;
                        outcome.code     = slot_code[i];
                        outcome.residual = slot_resid[i];
                        outcome.length   = slot_len[i];
                        slot_used[i]     = 1'b0;
                        slot_addr[i]     = '0;
                    end
                end
                if (outcome.hit) hits++;
            end
            due_events.push_back(outcome);
        endfunction

        function void check_result(t_completion seen);
            t_completion want;
            results++;
            if (due_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result hit=%0d code=%h res=%h len=%h ovw=%0d",
                             $time, seen.hit, seen.code, seen.residual, seen.length,
                             seen.overwrote);
                return;
            end
            want = due_events.pop_front();
            if (seen.hit !== want.hit || seen.code !== want.code ||
                seen.residual !== want.residual || seen.length !== want.length ||
                seen.overwrote !== want.overwrote) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result %0d mismatch", $time, results);
                    $display("  expected hit=%0d code=%h res=%h len=%h ovw=%0d",
                             want.hit, want.code, want.residual, want.length, want.overwrote);
                    $display("  actual   hit=%0d code=%h res=%h len=%h ovw=%0d",
                             seen.hit, seen.code, seen.residual, seen.length, seen.overwrote);
                end
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_command = esct_pkg::CMD_STORE;
    logic [esct_pkg::KEY_W-1:0]   i_key_address = '0;
    logic [esct_pkg::CODE_W-1:0]  i_in_code = '0;
    logic [esct_pkg::RESID_W-1:0] i_in_residual = '0;
    logic [esct_pkg::LEN_W-1:0]   i_in_length = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic                         o_hit;
    logic [esct_pkg::CODE_W-1:0]  o_out_code;
    logic [esct_pkg::RESID_W-1:0] o_out_residual;
    logic [esct_pkg::LEN_W-1:0]   o_out_length;
    logic                         o_overwrote;

    t_event_slot_predictor        slots;
    logic [esct_pkg::KEY_W-1:0]   live_keys [$];
    int                           items_sent = 0;
    int                           stuck_cycles = 0;
    int                           ready_hold = 0;
    bit                           quiet = 1'b0;

    event_side_cache_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_key_address  (i_key_address),
        .i_in_code      (i_in_code),
        .i_in_residual  (i_in_residual),
        .i_in_length    (i_in_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_out_code     (o_out_code),
        .o_out_residual (o_out_residual),
        .o_out_length   (o_out_length),
        .o_overwrote    (o_overwrote)
    );

    always #4 i_clk = ~i_clk;

    // Mostly no gap, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [esct_pkg::KEY_W-1:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 6) return {$urandom, $urandom};
        // Small pool of descriptor addresses so keys repeat.
        return 64'h0000_0001_2340_0000 + 64'($urandom_range(0, 15)) * 64'h40;
    endfunction

    function automatic logic [esct_pkg::KEY_W-1:0] pick_take_key();
        if (live_keys.size() != 0 && $urandom_range(0, 4) != 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return rand_key();
    endfunction

    task automatic send_item(input logic cmd, input logic [esct_pkg::KEY_W-1:0] key,
                             input logic [esct_pkg::CODE_W-1:0] code,
                             input logic [esct_pkg::RESID_W-1:0] resid,
                             input logic [esct_pkg::LEN_W-1:0] len);
        int gap;
        int i;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_key_address <= key;
        i_in_code     <= code;
        i_in_residual <= resid;
        i_in_length   <= len;
        do @(posedge i_clk); while (!o_in_ready);
        slots.note_item(cmd, key, code, resid, len);
        items_sent++;
        if (cmd == esct_pkg::CMD_STORE) begin
            live_keys.push_back(key);
        end else begin
            for (i = 0; i < live_keys.size(); i++) begin
                if (live_keys[i] == key) begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic send_store(input logic [esct_pkg::KEY_W-1:0] key);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            send_item(esct_pkg::CMD_STORE, key, '1, '1, '1);
        else if (r == 1)
            send_item(esct_pkg::CMD_STORE, key, '0, '0, '0);
        else
            send_item(esct_pkg::CMD_STORE, key, esct_pkg::CODE_W'($urandom),
                      esct_pkg::RESID_W'($urandom), esct_pkg::LEN_W'($urandom));
    endtask

    task automatic send_take(input logic [esct_pkg::KEY_W-1:0] key);
        send_item(esct_pkg::CMD_TAKE, key, esct_pkg::CODE_W'($urandom),
                  esct_pkg::RESID_W'($urandom), esct_pkg::LEN_W'($urandom));
    endtask

    // Result side: random stalls on ready.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= ready_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            slots.check_result({o_hit, o_out_code, o_out_residual, o_out_length, o_overwrote});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        while (stuck_cycles < WATCHDOG_CYCLES) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles, %0d results still pending",
                 $time, WATCHDOG_CYCLES, slots.due_events.size());
        $display("event_side_cache_table verification failed");
        $finish;
    end

    initial begin
        int kind;
        int n;
        int k;
        logic [esct_pkg::KEY_W-1:0] dup_key;
        slots = new();
        dup_key = 64'h0000_00FE_DCBA_9870;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table miss, field extremes, duplicates, freed slots.
        quiet = 1'b1;
        send_take('0);
        send_item(esct_pkg::CMD_STORE, '1, '1, '1, '1);
        send_item(esct_pkg::CMD_STORE, '0, '0, '0, '0);
        send_take('1);
        send_take('1);
        send_item(esct_pkg::CMD_STORE, dup_key, 8'h11, 24'h00_1234, 17'h0_0042);
        send_item(esct_pkg::CMD_STORE, dup_key, 8'hEE, 24'hFE_DCBA, 17'h1_FFF0);
        send_take(dup_key);
        send_take(dup_key);
        send_take(dup_key);
        send_take('0);
        send_item(esct_pkg::CMD_STORE, 64'h5555_5555_5555_5555, 8'hA5, 24'h5A_5A5A,
                  17'h1_5555);
        send_take(64'hAAAA_AAAA_AAAA_AAAA);
        send_take(64'h5555_5555_5555_5555);
        quiet = 1'b0;

        // Fill past capacity once so slot 0 gets replaced early.
        n = esct_pkg::ENTRIES - slots.occupancy() + 3;
        repeat (n) send_store(rand_key());

        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 5) == 0);
            kind  = $urandom_range(0, 9);
            if (kind < 4) begin
                // Store a batch, then take most of it back.
                n = $urandom_range(1, 12);
                repeat (n) send_store(rand_key());
                k = $urandom_range(n / 2, n + 2);
                repeat (k) send_take(pick_take_key());
            end else if (kind < 6) begin
                n = esct_pkg::ENTRIES - slots.occupancy() + $urandom_range(1, 4);
                repeat (n) send_store(rand_key());
            end else if (kind < 8) begin
                n = $urandom_range(4, esct_pkg::ENTRIES);
                repeat (n) send_take(pick_take_key());
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) begin
                    if ($urandom_range(0, 1) == 0)
                        send_store({$urandom, $urandom});
                    else
                        send_take({$urandom, $urandom});
                end
            end
        end
        i_in_valid <= 1'b0;

        while (slots.due_events.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d items: %0d stores (%0d replaced slot 0), %0d takes (%0d hit).",
                 items_sent, slots.stores, slots.replaced, slots.takes, slots.hits);
        $display("Checked %0d results, %0d mismatches.", slots.results, slots.mismatches);
        if (slots.mismatches == 0)
            $display("event_side_cache_table verification clean");
        else
            $display("event_side_cache_table verification failed");
        $finish;
    end
endmodule
